@@ src/stoc_pkg.sv @@
// stoc_pkg: shared types and constants for the sorted table occurrence counter
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none
package stoc_pkg;

  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int OCC_W   = 11;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    SRCH_IDLE,
    SRCH_ADDR,
    SRCH_CMP,
    SRCH_DONE
  } srch_state_e;

  // finished query as handed from the search sequencer to the output register
  typedef struct packed {
    logic             done;
    logic             found;
    logic [OCC_W-1:0] occurrences;
  } srch_result_t;

endpackage
`default_nettype wire

@@ src/stoc_if.sv @@
// stoc_if: valid/ready channels of the occurrence counter (request in, result out)
// depends on stoc_pkg for the field widths
`default_nettype none
interface stoc_in_if;
  import stoc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface stoc_out_if;
  import stoc_pkg::*;
  logic             valid;
  logic             ready;
  logic [OCC_W-1:0] occurrences;
  logic             found;

  modport source (output valid, output occurrences, output found, input ready);
  modport sink   (input valid, input occurrences, input found, output ready);
endinterface
`default_nettype wire

@@ src/stoc_table_ram.sv @@
// stoc_table_ram: table storage, one write port and one read port with registered data
// depends on stoc_pkg for the value width
`default_nettype none
module stoc_table_ram #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic                               clk_i,
  input  wire logic                               wr_en_i,
  input  wire logic [AW-1:0]                      wr_addr_i,
  input  wire logic signed [stoc_pkg::VALUE_W-1:0] wr_data_i,
  input  wire logic                               rd_en_i,
  input  wire logic [AW-1:0]                      rd_addr_i,
  output logic signed [stoc_pkg::VALUE_W-1:0]      rd_data_o
);
  import stoc_pkg::*;

  logic signed [VALUE_W-1:0] mem_q [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

@@ src/stoc_search.sv @@
// stoc_search: sequencer running the leftmost and rightmost binary searches
// over one shared compare/update unit; depends on stoc_pkg and reads stoc_table_ram
`default_nettype none
module stoc_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = $clog2(TABLE_DEPTH),
  parameter int UW          = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [stoc_pkg::VALUE_W-1:0] key_i,
  input  wire logic [UW-1:0]                       used_i,
  input  wire logic                                out_free_i,
  output logic                                     busy_o,
  output logic                                     rd_en_o,
  output logic [AW-1:0]                            rd_addr_o,
  input  wire logic signed [stoc_pkg::VALUE_W-1:0] rd_data_i,
  output stoc_pkg::srch_result_t                   result_o
);
  import stoc_pkg::*;

  localparam int IW = UW + 1;
  localparam int CW = (IW > OCC_W) ? IW : OCC_W;

  srch_state_e state_q, state_d;
  logic signed [IW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [IW-1:0] where_q, where_d, first_q, first_d;
  logic                 hit_q, hit_d, hit_first_q, hit_first_d, pass_q, pass_d;
  logic signed [VALUE_W-1:0] key_q, key_d;
  logic signed [IW-1:0] mid;
  logic signed [IW-1:0] span;
  logic [CW-1:0]        count;

  assign mid   = lo_q + ((hi_q - lo_q) >>> 1);
  assign span  = where_q - first_q + IW'(1);
  assign count = CW'($unsigned(span));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SRCH_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    where_q     <= where_d;
    first_q     <= first_d;
    hit_q       <= hit_d;
    hit_first_q <= hit_first_d;
    pass_q      <= pass_d;
    key_q       <= key_d;
  end

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    where_d     = where_q;
    first_d     = first_q;
    hit_d       = hit_q;
    hit_first_d = hit_first_q;
    pass_d      = pass_q;
    key_d       = key_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = mid[AW-1:0];
    result_o    = '0;

    unique case (state_q)
      SRCH_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          lo_d    = '0;
          hi_d    = IW'(used_i) - IW'(1);
          hit_d   = 1'b0;
          pass_d  = 1'b0;
          state_d = SRCH_ADDR;
        end
      end
      SRCH_ADDR: begin
        if (lo_q <= hi_q) begin
          rd_en_o = 1'b1;
          mid_d   = mid;
          state_d = SRCH_CMP;
        end else if (!pass_q) begin
          // leftmost pass finished, restart the window for the rightmost pass
          first_d     = where_q;
          hit_first_d = hit_q;
          hit_d       = 1'b0;
          lo_d        = '0;
          hi_d        = IW'(used_i) - IW'(1);
          pass_d      = 1'b1;
        end else begin
          state_d = SRCH_DONE;
        end
      end
      SRCH_CMP: begin
        state_d = SRCH_ADDR;
        if (rd_data_i == key_q) begin
          hit_d   = 1'b1;
          where_d = mid_q;
          if (!pass_q) begin
            hi_d = mid_q - IW'(1);
          end else begin
            lo_d = mid_q + IW'(1);
          end
        end else if (rd_data_i < key_q) begin
          lo_d = mid_q + IW'(1);
        end else begin
          hi_d = mid_q - IW'(1);
        end
      end
      SRCH_DONE: begin
        if (out_free_i) begin
          result_o.done = 1'b1;
          if (hit_first_q && hit_q && (where_q >= first_q)) begin
            result_o.found       = 1'b1;
            result_o.occurrences = count[OCC_W-1:0];
          end
          state_d = SRCH_IDLE;
        end
      end
      default: state_d = SRCH_IDLE;
    endcase
  end

  assign busy_o = (state_q != SRCH_IDLE);

`ifndef SYNTHESIS
  a_read_then_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |=> state_q == SRCH_CMP)
    else $error("table read not followed by compare");
  a_compare_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SRCH_CMP |-> $past(rd_en_o))
    else $error("compare without a table read");
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.done && !result_o.found |-> result_o.occurrences == '0)
    else $error("miss reported with nonzero count");
  a_done_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.done |-> out_free_i && state_q == SRCH_DONE)
    else $error("result issued without a free output slot");
`endif

endmodule
`default_nettype wire

@@ src/sorted_table_occurrence_counter.sv @@
// sorted_table_occurrence_counter: top level, request decode, entry count, output register
// depends on stoc_pkg, stoc_if, stoc_table_ram and stoc_search
//
//   channel  dir  fields               meaning
//   in_i     in   mode, value          append, query or clear request
//   out_o    out  occurrences, found   one result per query
//
// append and clear are taken while no query is in progress; a query runs two binary
// searches, leftmost then rightmost, of at most ceil(log2(entries + 1)) probes each, and
// each probe passes an address state and a compare state for the registered read of the single table port
// rst_ni clears the entry count and the control state; table contents are kept
// in_i is not ready while a query searches; a finished result waits in the output
// register while appends and clears go on, and the next result waits for that slot
`default_nettype none
module sorted_table_occurrence_counter #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stoc_in_if.sink    in_i,
  stoc_out_if.source out_o
);
  import stoc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);

  logic [UW-1:0]             used_q, used_d;
  logic                      out_valid_q;
  logic [OCC_W-1:0]          occ_q;
  logic                      found_q;
  logic                      busy;
  logic                      accept;
  logic                      start;
  logic                      wr_en;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_data;
  logic                      out_free;
  srch_result_t              result;

  assign in_i.ready = !busy;
  assign accept     = in_i.valid && in_i.ready;
  assign start      = accept && (in_i.mode == MODE_QUERY);
  assign wr_en      = accept && (in_i.mode == MODE_APPEND) && (used_q < UW'(TABLE_DEPTH));
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    used_d = used_q;
    if (accept && (in_i.mode == MODE_CLEAR)) begin
      used_d = '0;
    end else if (wr_en) begin
      used_d = used_q + UW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q <= used_d;
      if (result.done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.done) begin
      occ_q   <= result.occurrences;
      found_q <= result.found;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.occurrences = occ_q;
  assign out_o.found       = found_q;

  stoc_table_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (used_q[AW-1:0]),
    .wr_data_i (in_i.value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  stoc_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .UW          (UW)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .key_i      (in_i.value),
    .used_i     (used_q),
    .out_free_i (out_free),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .result_o   (result)
  );

`ifndef SYNTHESIS
  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> used_q == $past(used_q) + UW'(1))
    else $error("append did not advance the entry count");
  a_no_write_during_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !wr_en && used_q == $past(used_q))
    else $error("table changed during a search");
  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !result.done)
    else $error("result overwrote a pending one");
`endif

endmodule
`default_nettype wire
